// ===== design/prim_mst_pkg.sv =====
// Shared constants, payload types and control types of the spanning tree core.
package prim_mst_pkg;

    localparam int MAX_VERTS   = 64;
    localparam int WEIGHT_BITS = 16;
    localparam int VW          = $clog2(MAX_VERTS);
    localparam int NW          = $clog2(MAX_VERTS + 1);
    localparam int KW          = WEIGHT_BITS + 1;
    localparam int TOT_W       = 22;
    localparam int CNT_W       = $clog2(MAX_VERTS + 2);

    localparam logic [KW-1:0]    INF_KEY   = {1'b1, {WEIGHT_BITS{1'b0}}};
    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    typedef struct packed {
        logic [5:0]  vertex_a;
        logic [5:0]  vertex_b;
        logic [15:0] weight;
        logic        last;
    } t_edge;

    typedef struct packed {
        logic [5:0]       parent_vertex;
        logic [5:0]       child_vertex;
        logic [15:0]      edge_weight;
        logic             reached;
        logic [TOT_W-1:0] total_weight;
        logic             final_res;
    } t_res;

    typedef struct packed {
        logic [KW-1:0] key;
        logic [VW-1:0] idx;
    } t_tok;

    typedef enum logic [2:0] {
        C_NONE,
        C_LOAD,
        C_CLEAR,
        C_INIT,
        C_PICK,
        C_RELAX
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode             mode;
        logic [VW-1:0]          a;
        logic [VW-1:0]          b;
        logic [WEIGHT_BITS-1:0] w;
        logic [VW-1:0]          pick;
        logic [VW-1:0]          addr;
        logic [NW-1:0]          n;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_LOAD,
        S_INIT,
        S_WAIT,
        S_PICK,
        S_RELAX,
        S_OUT
    } t_state;

endpackage

// ===== design/prim_mst_edge_if.sv =====
// Edge input channel: valid, ready and one edge transaction.
interface prim_mst_edge_if;
    import prim_mst_pkg::*;
    logic  valid;
    logic  ready;
    t_edge data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/prim_mst_res_if.sv =====
// Result output channel: valid, ready and one tree edge transaction.
interface prim_mst_res_if;
    import prim_mst_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/prim_mst_cell.sv =====
// One vertex cell: adjacency column, key, parent, membership and min-search stage.
module prim_mst_cell (
    input  logic                             i_clk,
    input  logic [prim_mst_pkg::VW-1:0]      i_idx,
    input  prim_mst_pkg::t_cell_ctl          i_ctl,
    input  prim_mst_pkg::t_tok               i_tok,
    output prim_mst_pkg::t_tok               o_tok,
    output logic [prim_mst_pkg::KW-1:0]      o_key,
    output logic [prim_mst_pkg::VW-1:0]      o_par
);
    import prim_mst_pkg::*;

    logic [WEIGHT_BITS-1:0] r_mem [MAX_VERTS];
    logic [WEIGHT_BITS-1:0] r_rd;
    logic [KW-1:0]          r_key;
    logic [VW-1:0]          r_par;
    logic                   r_in;
    t_tok                   r_tok;

    logic                   w_we;
    logic [VW-1:0]          w_waddr;
    logic [WEIGHT_BITS-1:0] w_wdata;
    logic                   w_active;

    assign w_active = {1'b0, i_idx} < i_ctl.n;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = i_ctl.addr;
        w_wdata = '0;
        if (i_ctl.mode == C_CLEAR) begin
            w_we = 1'b1;
        end else if (i_ctl.mode == C_LOAD) begin
            w_we    = (i_idx == i_ctl.a) || (i_idx == i_ctl.b);
            w_waddr = (i_idx == i_ctl.a) ? i_ctl.b : i_ctl.a;
            w_wdata = i_ctl.w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[i_ctl.pick];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.mode)
            C_INIT: begin
                r_key <= (i_idx == '0) ? '0 : INF_KEY;
                r_par <= '0;
                r_in  <= 1'b0;
            end
            C_PICK: begin
                if (i_idx == i_ctl.pick) begin
                    r_in <= 1'b1;
                end
            end
            C_RELAX: begin
                if (r_rd != '0 && !r_in && {1'b0, r_rd} < r_key) begin
                    r_key <= {1'b0, r_rd};
                    r_par <= i_ctl.pick;
                end
            end
            C_NONE, C_LOAD, C_CLEAR: begin
            end
            default: begin
            end
        endcase
    end

    // pass the cheaper candidate toward the tail; ties keep the lower vertex
    always_ff @(posedge i_clk) begin
        if (w_active && !r_in && r_key < i_tok.key) begin
            r_tok <= '{key: r_key, idx: i_idx};
        end else begin
            r_tok <= i_tok;
        end
    end

    assign o_tok = r_tok;
    assign o_key = r_key;
    assign o_par = r_par;

endmodule

// ===== design/prim_mst_core.sv =====
// Top level of the minimum spanning tree core: sequencer, output register and cell chain.
// Channels: i_edge takes one edge transaction per cycle while the store is loading;
//   o_res returns one transaction per vertex 1 .. n-1 in ascending order, the last flagged.
// i_cfg_we/i_cfg_data set the vertex count; write it only while no graph is in flight.
// After reset the store is cleared with i_edge.ready low.
// The transaction marked last starts the solve and drops i_edge.ready until the results
//   are out and the store is cleared again.
// Solve: an init step, then per vertex that joins the tree a wait for the minimum to
//   ripple down the chain, a pick and a relax, then a last wait that finds that no
//   candidate is left.
// Results: the first is registered when the solve ends, then one per cycle while ready.
// A stalled receiver holds the output register and the sequencer; nothing is dropped.
// After the final result is taken into the output register, a clear pass runs
//   before edges load again.
module prim_minimum_spanning_tree_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [6:0]             i_cfg_data,
    prim_mst_edge_if.sink          i_edge,
    prim_mst_res_if.source         o_res
);
    import prim_mst_pkg::*;

    t_state           r_state, n_state;
    logic [NW-1:0]    r_vc;
    logic [NW-1:0]    r_n;
    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_pick;
    logic [NW-1:0]    r_v;
    logic [TOT_W-1:0] r_sum;
    logic             r_ov;
    t_res             r_res;

    t_cell_ctl        w_ctl;
    t_tok             w_chain [MAX_VERTS+1];
    logic [KW-1:0]    w_key   [MAX_VERTS];
    logic [VW-1:0]    w_par   [MAX_VERTS];

    logic             w_acc;
    logic             w_emit;
    logic [NW-1:0]    w_n;
    logic [KW-1:0]    w_skey;
    logic             w_ok;
    logic [15:0]      w_ew;
    logic [TOT_W:0]   w_sum_ext;
    logic [TOT_W-1:0] w_sum;

    assign w_acc = i_edge.valid && i_edge.ready;
    assign i_edge.ready = (r_state == S_LOAD);

    always_comb begin
        if (r_vc == '0) begin
            w_n = NW'(1);
        end else if (r_vc > NW'(MAX_VERTS)) begin
            w_n = NW'(MAX_VERTS);
        end else begin
            w_n = r_vc;
        end
    end

    assign w_chain[0] = '{key: INF_KEY, idx: '0};

    for (genvar g = 0; g < MAX_VERTS; g++) begin : g_cell
        prim_mst_cell u_cell (
            .i_clk (i_clk),
            .i_idx (VW'(g)),
            .i_ctl (w_ctl),
            .i_tok (w_chain[g]),
            .o_tok (w_chain[g+1]),
            .o_key (w_key[g]),
            .o_par (w_par[g])
        );
    end

    assign w_emit    = (r_state == S_OUT) && (!r_ov || o_res.ready);
    assign w_skey    = w_key[r_v[VW-1:0]];
    assign w_ok      = (w_skey < INF_KEY);
    assign w_ew      = w_ok ? 16'(w_skey[WEIGHT_BITS-1:0]) : '0;
    assign w_sum_ext = {1'b0, r_sum} + (TOT_W+1)'(w_ew);
    assign w_sum     = (w_sum_ext > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : w_sum_ext[TOT_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_cnt == CNT_W'(MAX_VERTS - 1)) n_state = S_LOAD;
            S_LOAD:  if (w_acc && i_edge.data.last) n_state = S_INIT;
            S_INIT:  n_state = S_WAIT;
            S_WAIT: begin
                if (r_cnt == CNT_W'(MAX_VERTS + 1)) begin
                    if (w_chain[MAX_VERTS].key != INF_KEY) begin
                        n_state = S_PICK;
                    end else if (r_n > NW'(1)) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_PICK:  n_state = S_RELAX;
            S_RELAX: n_state = S_WAIT;
            S_OUT:   if (w_emit && r_v == r_n - NW'(1)) n_state = S_CLEAR;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        w_ctl      = '0;
        w_ctl.mode = C_NONE;
        w_ctl.a    = i_edge.data.vertex_a;
        w_ctl.b    = i_edge.data.vertex_b;
        w_ctl.w    = i_edge.data.weight[WEIGHT_BITS-1:0];
        w_ctl.pick = r_pick;
        w_ctl.addr = r_cnt[VW-1:0];
        w_ctl.n    = r_n;
        unique case (r_state)
            S_CLEAR: w_ctl.mode = C_CLEAR;
            S_LOAD:  w_ctl.mode = w_acc ? C_LOAD : C_NONE;
            S_INIT:  w_ctl.mode = C_INIT;
            S_PICK:  w_ctl.mode = C_PICK;
            S_RELAX: w_ctl.mode = C_RELAX;
            S_WAIT, S_OUT: w_ctl.mode = C_NONE;
            default: w_ctl.mode = C_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_vc    <= NW'(MAX_VERTS);
            r_n     <= NW'(1);
            r_cnt   <= '0;
            r_pick  <= '0;
            r_v     <= NW'(1);
            r_sum   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_vc <= i_cfg_data;
            end
            if (r_state != n_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_state == S_INIT) begin
                r_n   <= w_n;
                r_sum <= '0;
                r_v   <= NW'(1);
            end
            if (r_state == S_WAIT) begin
                r_pick <= w_chain[MAX_VERTS].idx;
            end
            if (w_emit) begin
                r_ov  <= 1'b1;
                r_sum <= w_sum;
                r_v   <= r_v + NW'(1);
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_res.parent_vertex <= w_ok ? w_par[r_v[VW-1:0]] : '0;
            r_res.child_vertex  <= r_v[VW-1:0];
            r_res.edge_weight   <= w_ew;
            r_res.reached       <= w_ok;
            r_res.total_weight  <= w_sum;
            r_res.final_res     <= (r_v == r_n - NW'(1));
        end
    end

    assign o_res.valid = r_ov;
    assign o_res.data  = r_res;

    a_unreached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.data.reached |->
            o_res.data.parent_vertex == '0 && o_res.data.edge_weight == '0)
        else $error("unreached vertex reports nonzero edge");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_v < r_n && r_v != '0)
        else $error("output vertex out of range");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_edge.data.last |=> !i_edge.ready)
        else $error("input accepted during solve");

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the spanning tree core: directed table, random graphs, predicted tree checks.
module testbench;
    import prim_mst_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [6:0] i_cfg_data;

    prim_mst_edge_if edge_ch();
    prim_mst_res_if  res_ch();

    prim_minimum_spanning_tree_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_edge     (edge_ch.sink),
        .o_res      (res_ch.source)
    );

    typedef struct {
        t_edge e;
        bit    has_res;
        t_res  r;
    } t_row;

    logic [15:0] graph_w [64][64];
    logic [6:0]  vcount_shadow;
    t_res        tree_q[$];
    int          errors;
    bit          calm;
    bit          hold_long;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    task automatic solve_tree();
        int n;
        logic [16:0] key [64];
        logic [5:0]  par [64];
        bit          done [64];
        int          pick;
        logic [16:0] pk;
        logic [21:0] sum;
        t_res        r;
        n = vcount_shadow;
        if (n == 0) n = 1;
        if (n > MAX_VERTS) n = MAX_VERTS;
        for (int i = 0; i < n; i++) begin
            key[i] = INF_KEY;
            par[i] = 0;
            done[i] = 0;
        end
        key[0] = 0;
        for (int rd = 0; rd < n; rd++) begin
            pick = -1;
            pk = INF_KEY;
            for (int i = 0; i < n; i++)
                if (!done[i] && key[i] < pk) begin
                    pk = key[i];
                    pick = i;
                end
            if (pick < 0) break;
            done[pick] = 1;
            for (int i = 0; i < n; i++)
                if (graph_w[pick][i] != 0 && !done[i] && {1'b0, graph_w[pick][i]} < key[i]) begin
                    key[i] = {1'b0, graph_w[pick][i]};
                    par[i] = pick[5:0];
                end
        end
        sum = 0;
        for (int v = 1; v < n; v++) begin
            r.reached = key[v] < INF_KEY;
            r.edge_weight = r.reached ? key[v][15:0] : 16'd0;
            r.parent_vertex = r.reached ? par[v] : 6'd0;
            r.child_vertex = v[5:0];
            if ({1'b0, sum} + r.edge_weight > TOTAL_MAX) sum = TOTAL_MAX;
            else sum = sum + r.edge_weight;
            r.total_weight = sum;
            r.final_res = (v == n - 1);
            tree_q.push_back(r);
        end
        for (int i = 0; i < 64; i++)
            for (int j = 0; j < 64; j++)
                graph_w[i][j] = 0;
    endtask

    task automatic load_edge(input t_edge e);
        graph_w[e.vertex_a][e.vertex_b] = e.weight;
        graph_w[e.vertex_b][e.vertex_a] = e.weight;
        if (e.last) solve_tree();
    endtask

    task automatic send_edge(input t_edge e);
        if (!calm && $urandom_range(0, 5) == 0) begin
            edge_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        edge_ch.valid <= 1'b1;
        edge_ch.data  <= e;
        @(posedge i_clk);
        while (!edge_ch.ready) @(posedge i_clk);
        load_edge(e);
    endtask

    task automatic send_edge_raw(input t_edge e);
        edge_ch.valid <= 1'b1;
        edge_ch.data  <= e;
        @(posedge i_clk);
        while (!edge_ch.ready) @(posedge i_clk);
    endtask

    task automatic go_idle();
        edge_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tree_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [6:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        vcount_shadow = v;
        @(posedge i_clk);
    endtask

    function automatic t_edge rand_edge(input int n, input bit lst);
        t_edge e;
        int m;
        m = (n < 1) ? 1 : ((n > 64) ? 64 : n);
        e.vertex_a = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, m - 1));
        e.vertex_b = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, m - 1));
        case ($urandom_range(0, 3))
            0: e.weight = 16'($urandom);
            1: e.weight = 16'($urandom_range(1, 20));
            2: e.weight = 16'hFFFF - 16'($urandom_range(0, 3));
            default: e.weight = 16'($urandom_range(0, 300));
        endcase
        e.last = lst;
        return e;
    endfunction

    // result side
    always @(posedge i_clk) begin
        t_res got;
        t_res exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (tree_q.size() == 0) begin
                $error("unexpected result child=%0d", got.child_vertex);
                errors++;
            end else begin
                exp_r = tree_q.pop_front();
                if (got.parent_vertex !== exp_r.parent_vertex) begin
                    $error("parent_vertex exp %0d got %0d", exp_r.parent_vertex, got.parent_vertex);
                    errors++;
                end
                if (got.child_vertex !== exp_r.child_vertex) begin
                    $error("child_vertex exp %0d got %0d", exp_r.child_vertex, got.child_vertex);
                    errors++;
                end
                if (got.edge_weight !== exp_r.edge_weight) begin
                    $error("edge_weight exp %0d got %0d", exp_r.edge_weight, got.edge_weight);
                    errors++;
                end
                if (got.reached !== exp_r.reached) begin
                    $error("reached exp %0d got %0d", exp_r.reached, got.reached);
                    errors++;
                end
                if (got.total_weight !== exp_r.total_weight) begin
                    $error("total_weight exp %0d got %0d", exp_r.total_weight, got.total_weight);
                    errors++;
                end
                if (got.final_res !== exp_r.final_res) begin
                    $error("final_res exp %0d got %0d", exp_r.final_res, got.final_res);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                res_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_long = 0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 8);
                res_ch.ready <= 1'b0;
                repeat (gap - 1) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #200000000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        t_row  rows[$];
        t_row  row;
        t_edge e;
        int    n;
        int    k;
        logic [6:0] counts [6];
        errors = 0;
        calm = 0;
        hold_long = 0;
        vcount_shadow = 7'd64;
        for (int i = 0; i < 64; i++)
            for (int j = 0; j < 64; j++)
                graph_w[i][j] = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 7'd0;
        edge_ch.valid = 1'b0;
        edge_ch.data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: two vertices, extremes, self loop, out-of-range, disconnect
        write_count(7'd2);
        row.e = '{6'd0, 6'd1, 16'hFFFF, 1'b1}; row.has_res = 1;
        row.r = '{6'd0, 6'd1, 16'hFFFF, 1'b1, 22'hFFFF, 1'b1};
        rows.push_back(row);
        row.e = '{6'd1, 6'd1, 16'd5, 1'b1}; row.has_res = 1;
        row.r = '{6'd0, 6'd1, 16'd0, 1'b0, 22'd0, 1'b1};
        rows.push_back(row);
        row.e = '{6'd63, 6'd0, 16'd7, 1'b0}; row.has_res = 0; rows.push_back(row);
        row.e = '{6'd1, 6'd0, 16'd1, 1'b1}; row.has_res = 1;
        row.r = '{6'd0, 6'd1, 16'd1, 1'b1, 22'd1, 1'b1};
        rows.push_back(row);
        row.e = '{6'd0, 6'd1, 16'd9, 1'b0}; row.has_res = 0; rows.push_back(row);
        row.e = '{6'd0, 6'd1, 16'd0, 1'b1}; row.has_res = 1;
        row.r = '{6'd0, 6'd1, 16'd0, 1'b0, 22'd0, 1'b1};
        rows.push_back(row);
        foreach (rows[i]) begin
            if (rows[i].e.last && rows[i].has_res) begin
                load_edge(rows[i].e);
                void'(tree_q.pop_back());
                tree_q.push_back(rows[i].r);
                send_edge_raw(rows[i].e);
            end else begin
                send_edge(rows[i].e);
            end
        end
        go_idle();

        // zero count gives no results; then ties and chain at count 4; then an oversized count
        write_count(7'd0);
        send_edge('{6'd0, 6'd1, 16'd3, 1'b1});
        go_idle();
        write_count(7'd4);
        send_edge('{6'd0, 6'd1, 16'd2, 1'b0});
        send_edge('{6'd0, 6'd2, 16'd2, 1'b0});
        send_edge('{6'd1, 6'd3, 16'd2, 1'b0});
        send_edge('{6'd2, 6'd3, 16'd2, 1'b1});
        go_idle();
        write_count(7'd127);
        send_edge('{6'd63, 6'd62, 16'hFFFF, 1'b1});
        go_idle();

        // random graphs across several counts
        counts = '{7'd64, 7'd1, 7'd3, 7'd8, 7'd16, 7'd100};
        k = 0;
        for (int ph = 0; ph < 12; ph++) begin
            write_count((ph < 6) ? counts[ph] : 7'($urandom_range(0, 127)));
            n = vcount_shadow;
            if (ph == 3) hold_long = 1;
            if (ph == 10) calm = 1;
            for (int g = 0; g < 4; g++) begin
                int len;
                len = $urandom_range(1, 12);
                for (int j = 0; j < len; j++) begin
                    send_edge(rand_edge(n, j == len - 1));
                    k++;
                end
            end
            go_idle();
        end
        while (k < 480) begin
            send_edge(rand_edge(8, $urandom_range(0, 9) == 0));
            k++;
        end
        send_edge(rand_edge(8, 1'b1));
        go_idle();

        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/prim_mst_pkg.sv
design/prim_mst_edge_if.sv
design/prim_mst_res_if.sv
design/prim_mst_cell.sv
design/prim_mst_core.sv
tb/sv/testbench.sv
